// File: sv/aff_pkg.sv
// Package for the affine transform accumulator.
// Holds command codes, the CORDIC arctangent table and shared types.
// No dependencies.
package aff_pkg;

  localparam int ATAN_STEPS = 24;

  localparam logic [2:0] CMD_IDENT = 3'd0;
  localparam logic [2:0] CMD_TRANS = 3'd1;
  localparam logic [2:0] CMD_SCALE = 3'd2;
  localparam logic [2:0] CMD_ROTX  = 3'd3;
  localparam logic [2:0] CMD_ROTY  = 3'd4;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } aff_trig_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0: v = 32'h20000000;
      5'd1: v = 32'h12E4051E;
      5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4;
      5'd4: v = 32'h028B0D43;
      5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;
      5'd7: v = 32'h00517C55;
      5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/affine_transform_accumulator.sv
// Top level of the affine transform accumulator: 4x4 Q16.16 matrix in a
// two-bank memory, premultiplied by elementary transforms.
// Depends on aff_pkg and aff_cordic.
//
// Usage: drive in_command and operands with start; the item is taken when
// start is high and busy is low. Busy stays high until the run completes.
// Rotations first run the CORDIC. The multiply pass then issues 64 memory
// reads, one per cycle, each feeding one 32x32 multiply-accumulate; the
// sixteen elements appear on out_valid with out_element_index,
// out_element_value, out_saturated and out_last. The single memory read
// port paces the pass. The receiver must take each element in the cycle it
// is shown. Reset reloads identity.
module affine_transform_accumulator #(
  parameter int FRACTION_BITS = 16,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_operand_x,
  input  logic signed [31:0] in_operand_y,
  input  logic [15:0]        in_angle,
  output logic               out_valid,
  output logic [3:0]         out_element_index,
  output logic signed [31:0] out_element_value,
  output logic               out_saturated,
  output logic               out_last
);
  import aff_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CORD = 2'd1;
  localparam logic [1:0] ST_MAC  = 2'd2;

  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRACTION_BITS;
  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRACTION_BITS - 1);
  localparam logic signed [65:0] VMAX = 66'sd2147483647;
  localparam logic signed [65:0] VMIN = -66'sd2147483648;

  logic [1:0]         state_r;
  logic [2:0]         cmd_r;
  logic signed [31:0] ox_r, oy_r, c_r, s_r;
  logic               bank_r, init_r;
  logic [6:0]         cnt_r;
  logic               accept, issue;
  aff_trig_t          trig;

  logic [31:0]        mem [32];
  logic [31:0]        rdata_r;

  logic               s1_v_r, s2_v_r, s3_done_r;
  logic [3:0]         s1_e_r, s2_e_r, s3_e_r;
  logic [1:0]         s1_k_r, s2_k_r;
  logic signed [63:0] prod_r;
  logic signed [65:0] acc_r, acc_nxt, rnd;
  logic signed [31:0] m_op, t_val, v_sat;
  logic               use_ident, sat;
  logic [3:0]         tidx;

  logic               out_valid_r, out_sat_r, out_last_r;
  logic [3:0]         out_idx_r;
  logic signed [31:0] out_val_r;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign issue  = (state_r == ST_MAC) && !cnt_r[6];

  aff_cordic #(.FRACTION_BITS(FRACTION_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (accept && (in_command == CMD_ROTX || in_command == CMD_ROTY)),
    .angle (in_angle),
    .trig  (trig)
  );

  assign use_ident = init_r || (cmd_r == CMD_IDENT);
  assign m_op = use_ident ? ((s1_e_r[3:2] == s1_k_r) ? ONE : 32'sd0) : $signed(rdata_r);
  assign tidx = {s1_k_r, s1_e_r[1:0]};

  always_comb begin
    t_val = (tidx == 4'd0 || tidx == 4'd5 || tidx == 4'd10 || tidx == 4'd15) ? ONE : 32'sd0;
    unique case (cmd_r)
      CMD_TRANS: begin
        if (tidx == 4'd12) t_val = ox_r;
        if (tidx == 4'd13) t_val = oy_r;
      end
      CMD_SCALE: begin
        if (tidx == 4'd0) t_val = ox_r;
        if (tidx == 4'd5) t_val = oy_r;
      end
      CMD_ROTX: begin
        if (tidx == 4'd5 || tidx == 4'd10) t_val = c_r;
        if (tidx == 4'd6) t_val = s_r;
        if (tidx == 4'd9) t_val = -s_r;
      end
      CMD_ROTY: begin
        if (tidx == 4'd0 || tidx == 4'd10) t_val = c_r;
        if (tidx == 4'd2) t_val = -s_r;
        if (tidx == 4'd8) t_val = s_r;
      end
      default: ;
    endcase
  end

  assign acc_nxt = ((s2_k_r == 2'd0) ? 66'sd0 : acc_r) + 66'(prod_r);
  assign rnd     = (acc_r + HALF) >>> FRACTION_BITS;

  always_comb begin
    sat   = 1'b0;
    v_sat = rnd[31:0];
    if (rnd > VMAX) begin
      sat   = 1'b1;
      v_sat = 32'sh7FFFFFFF;
    end else if (rnd < VMIN) begin
      sat   = 1'b1;
      v_sat = 32'sh80000000;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata_r <= mem[{bank_r, cnt_r[5:4], cnt_r[1:0]}];
    end
    if (s3_done_r) begin
      mem[{~bank_r, s3_e_r}] <= v_sat;
    end
  end

  always_ff @(posedge clk) begin
    s1_e_r <= cnt_r[5:2];
    s1_k_r <= cnt_r[1:0];
    s2_e_r <= s1_e_r;
    s2_k_r <= s1_k_r;
    s3_e_r <= s2_e_r;
    if (s1_v_r) prod_r <= m_op * t_val;
    if (s2_v_r) acc_r <= acc_nxt;
    out_idx_r  <= s3_e_r;
    out_val_r  <= v_sat;
    out_sat_r  <= sat;
    out_last_r <= (s3_e_r == 4'd15);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bank_r      <= 1'b0;
      init_r      <= 1'b1;
      cnt_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_done_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= issue;
      s2_v_r      <= s1_v_r;
      s3_done_r   <= s2_v_r && (s2_k_r == 2'd3);
      out_valid_r <= s3_done_r;
      if (issue) cnt_r <= cnt_r + 7'd1;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cmd_r <= in_command;
            ox_r  <= in_operand_x;
            oy_r  <= in_operand_y;
            cnt_r <= '0;
            state_r <= (in_command == CMD_ROTX || in_command == CMD_ROTY) ? ST_CORD : ST_MAC;
          end
        end
        ST_CORD: begin
          if (trig.done) begin
            c_r     <= trig.cos_v;
            s_r     <= trig.sin_v;
            state_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (out_valid_r && out_last_r) begin
            state_r <= ST_IDLE;
            bank_r  <= ~bank_r;
            init_r  <= 1'b0;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_element_index = out_idx_r;
  assign out_element_value = out_val_r;
  assign out_saturated     = out_sat_r;
  assign out_last          = out_last_r;

  a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("element shown outside a run");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !busy) else $error("run did not end after last element");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted item did not start a run");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !issue && !s3_done_r) else $error("memory traffic while idle");

endmodule

// File: sv/aff_cordic.sv
// Iterative rotation-mode CORDIC producing cosine and sine of a binary angle.
// One step per cycle in Q2.30, result rounded to the matrix fixed-point format.
// Depends on aff_pkg.
module aff_cordic #(
  parameter int FRACTION_BITS = 16,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [15:0]       angle,
  output aff_pkg::aff_trig_t trig
);
  import aff_pkg::*;

  localparam int STEPS = (CORDIC_STEPS > ATAN_STEPS) ? ATAN_STEPS : CORDIC_STEPS;
  localparam int SH    = 30 - FRACTION_BITS;
  localparam logic signed [33:0] HALF = 34'sd1 <<< (SH - 1);

  logic               run_r, done_r, flip_r;
  logic [4:0]         cnt_r;
  logic signed [33:0] x_r, y_r;
  logic signed [32:0] z_r, z0;
  logic signed [31:0] cos_r, sin_r;
  logic signed [33:0] xs, ys, xrnd, yrnd;
  logic signed [32:0] at;

  assign z0   = {angle[15], angle, 16'b0};
  assign xs   = x_r >>> cnt_r;
  assign ys   = y_r >>> cnt_r;
  assign at   = {1'b0, atan_entry(cnt_r)};
  assign xrnd = (x_r + HALF) >>> SH;
  assign yrnd = (y_r + HALF) >>> SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        x_r   <= CORDIC_GAIN;
        y_r   <= '0;
        if (z0 > 33'sh040000000) begin
          z_r    <= z0 - 33'sh080000000;
          flip_r <= 1'b1;
        end else if (z0 < -33'sh040000000) begin
          z_r    <= z0 + 33'sh080000000;
          flip_r <= 1'b1;
        end else begin
          z_r    <= z0;
          flip_r <= 1'b0;
        end
      end else if (run_r) begin
        if (cnt_r == 5'(STEPS)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
          cos_r  <= flip_r ? -xrnd[31:0] : xrnd[31:0];
          sin_r  <= flip_r ? -yrnd[31:0] : yrnd[31:0];
        end else begin
          cnt_r <= cnt_r + 5'd1;
          if (!z_r[32]) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + at;
          end
        end
      end
    end
  end

  assign trig.done  = done_r;
  assign trig.cos_v = cos_r;
  assign trig.sin_v = sin_r;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for affine_transform_accumulator.
// Predicts every matrix element after each command and checks the strobed results.
// Depends on aff_pkg and the affine_transform_accumulator RTL.
`timescale 1ns / 1ps

module testbench;
  import aff_pkg::*;

  localparam int FB = 16;
  localparam int STEPS = 16;

  typedef struct {
    logic [3:0]         idx;
    logic signed [31:0] value;
    logic               sat;
    logic               last;
  } element_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [2:0]         in_command = '0;
  logic signed [31:0] in_operand_x = '0;
  logic signed [31:0] in_operand_y = '0;
  logic [15:0]        in_angle = '0;
  logic               busy;
  logic               out_valid;
  logic [3:0]         out_element_index;
  logic signed [31:0] out_element_value;
  logic               out_saturated;
  logic               out_last;

  longint   matrix [16];
  element_t pending_elements[$];
  int       mismatches = 0;
  int       elements_checked = 0;
  int       items_sent = 0;
  int       idle_pct = 38;

  affine_transform_accumulator #(.FRACTION_BITS(FB), .CORDIC_STEPS(STEPS)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_operand_x(in_operand_x),
    .in_operand_y(in_operand_y), .in_angle(in_angle),
    .out_valid(out_valid), .out_element_index(out_element_index),
    .out_element_value(out_element_value), .out_saturated(out_saturated),
    .out_last(out_last)
  );

  always #1 clk = ~clk;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  task automatic compute_sin_cos(input logic [15:0] ang, output longint c, output longint s);
    longint z, x, y, nx, ny;
    bit flip;
    int sh;
    z = longint'(ang) <<< 16;
    x = 652032874;
    y = 0;
    flip = 0;
    sh = 30 - FB;
    if (z >= 64'sh80000000) z -= 64'sh100000000;
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000;
      flip = 1;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000;
      flip = 1;
    end
    for (int i = 0; i < ((STEPS > 24) ? 24 : STEPS); i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        ny = y + floor_shift(x, i);
        z -= longint'(atan_entry(i[4:0]));
      end else begin
        nx = x + floor_shift(y, i);
        ny = y - floor_shift(x, i);
        z += longint'(atan_entry(i[4:0]));
      end
      x = nx;
      y = ny;
    end
    x = floor_shift(x + (64'sd1 <<< (sh - 1)), sh);
    y = floor_shift(y + (64'sd1 <<< (sh - 1)), sh);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_command(input logic [2:0] cmd, input logic signed [31:0] ox,
                                 input logic signed [31:0] oy, input logic [15:0] ang);
    longint t[16];
    longint res[16];
    bit     sat[16];
    longint c, s, hi, lo, p, h, v;
    element_t e;
    for (int k = 0; k < 16; k++) begin
      t[k] = (k % 5 == 0) ? (64'sd1 <<< FB) : 0;
      sat[k] = 0;
    end
    if (cmd == CMD_ROTX || cmd == CMD_ROTY) compute_sin_cos(ang, c, s);
    case (cmd)
      CMD_TRANS: begin
        t[12] = ox;
        t[13] = oy;
      end
      CMD_SCALE: begin
        t[0] = ox;
        t[5] = oy;
      end
      CMD_ROTX: begin
        t[5] = c; t[6] = s; t[9] = -s; t[10] = c;
      end
      CMD_ROTY: begin
        t[0] = c; t[2] = -s; t[8] = s; t[10] = c;
      end
      default: ;
    endcase
    if (cmd == CMD_IDENT) begin
      foreach (matrix[k]) matrix[k] = (k % 5 == 0) ? (64'sd1 <<< FB) : 0;
    end else if (cmd inside {CMD_TRANS, CMD_SCALE, CMD_ROTX, CMD_ROTY}) begin
      for (int col = 0; col < 4; col++) begin
        for (int r = 0; r < 4; r++) begin
          hi = 0;
          lo = 0;
          for (int k = 0; k < 4; k++) begin
            p = t[k*4+r] * matrix[col*4+k];
            h = floor_shift(p, FB);
            hi += h;
            lo += p - (h <<< FB);
          end
          v = hi + floor_shift(lo + (64'sd1 <<< (FB - 1)), FB);
          if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
            sat[col*4+r] = 1;
          end else if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
            sat[col*4+r] = 1;
          end
          res[col*4+r] = v;
        end
      end
      foreach (matrix[k]) matrix[k] = res[k];
    end
    for (int k = 0; k < 16; k++) begin
      e.idx = k[3:0];
      e.value = matrix[k][31:0];
      e.sat = sat[k];
      e.last = (k == 15);
      pending_elements.push_back(e);
    end
  endtask

  task automatic send_command(input logic [2:0] cmd, input logic signed [31:0] ox,
                              input logic signed [31:0] oy, input logic [15:0] ang);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_operand_x <= ox;
    in_operand_y <= oy;
    in_angle <= ang;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_command(cmd, ox, oy, ang);
    items_sent++;
  endtask

  always @(posedge clk) begin
    element_t e;
    if (rst_n && out_valid) begin
      elements_checked++;
      if (pending_elements.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected element index %0d", out_element_index);
      end else begin
        e = pending_elements.pop_front();
        if (out_element_index !== e.idx || out_element_value !== e.value ||
            out_saturated !== e.sat || out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected idx %0d val %0d sat %0b last %0b, got %0d %0d %0b %0b",
                     e.idx, e.value, e.sat, e.last, out_element_index,
                     out_element_value, out_saturated, out_last);
        end
      end
    end
  end

  function automatic logic signed [31:0] random_q(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(131072)) - 65536;
      default: return $signed($urandom_range(8192)) + 61440;
    endcase
  endfunction

  task automatic test_directed();
    send_command(CMD_IDENT, 0, 0, 0);
    send_command(CMD_TRANS, 32'sh7FFFFFFF, 32'sh80000000, 16'hFFFF);
    send_command(CMD_TRANS, 32'sh7FFFFFFF, 32'sh80000000, 0);
    send_command(CMD_SCALE, 32'sh80000000, 32'sh7FFFFFFF, 0);
    send_command(CMD_SCALE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
    send_command(CMD_IDENT, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    send_command(CMD_ROTX, 0, 0, 16'h0000);
    send_command(CMD_ROTX, 0, 0, 16'h4000);
    send_command(CMD_ROTX, 0, 0, 16'h4001);
    send_command(CMD_ROTX, 0, 0, 16'h8000);
    send_command(CMD_ROTY, 0, 0, 16'hC000);
    send_command(CMD_ROTY, 0, 0, 16'hBFFF);
    send_command(CMD_ROTY, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    send_command(3'd5, 1, 1, 1);
    send_command(3'd6, 0, 0, 0);
    send_command(3'd7, 32'hFFFFFFFF, 0, 16'hFFFF);
    send_command(CMD_SCALE, 32'sh00010000, 32'shFFFF0000, 0);
    send_command(CMD_IDENT, 0, 0, 0);
  endtask

  task automatic test_random(input int count);
    logic [2:0] cmd;
    int r;
    for (int i = 0; i < count; i++) begin
      idle_pct = (i >= count / 3 && i < count / 2) ? 0 : 38;
      r = $urandom_range(99);
      if (r < 5) cmd = CMD_IDENT;
      else if (r < 25) cmd = CMD_TRANS;
      else if (r < 45) cmd = CMD_SCALE;
      else if (r < 70) cmd = CMD_ROTX;
      else if (r < 95) cmd = CMD_ROTY;
      else cmd = 3'($urandom_range(7, 5));
      send_command(cmd, random_q($urandom_range(2)), random_q($urandom_range(2)),
                   16'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (matrix[k]) matrix[k] = (k % 5 == 0) ? (64'sd1 <<< FB) : 0;
    @(posedge clk);
    test_directed();
    test_random(352);
    start <= 1'b0;
    while (pending_elements.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d commands of all five kinds plus unused codes; checked %0d elements.",
             items_sent, elements_checked);
    if (mismatches == 0 && pending_elements.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout after %0d commands.", items_sent);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: sim.f
sv/aff_pkg.sv
sv/aff_cordic.sv
sv/affine_transform_accumulator.sv
tb/testbench.sv
